FILE: hw/rtl/stcsu_pkg.sv
// ----------------------------------------------------------------------------
// stcsu_pkg
// Shared types and constants of the tensor count sketch update engine.
// ----------------------------------------------------------------------------
package stcsu_pkg;

  // default sizes
  localparam int ROWS_DEF        = 4;
  localparam int BUCKET_BITS_DEF = 10;
  localparam int INDEX_DEPTH_DEF = 1024;
  localparam int MAX_MODES_DEF   = 3;

  // fixed field widths
  localparam int ACC_W  = 48;
  localparam int VAL_W  = 32;
  localparam int DLT_W  = VAL_W + 1;
  localparam int IDX_W  = 10;
  localparam int BKT_W  = 10;
  localparam int ROWF_W = 2;
  localparam int MODE_W = 2;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_READ  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  // sketch memory commands
  typedef struct packed {
    logic rd;   // read entry at addr
    logic acc;  // write back read data plus delta, saturated
    logic clr;  // write zero at addr
  } sk_ctrl_t;

endpackage

FILE: hw/rtl/stcsu_sketch.sv
// ----------------------------------------------------------------------------
// stcsu_sketch
// Sketch bucket memory with saturating read-modify-write accumulator.
// ----------------------------------------------------------------------------
module stcsu_sketch
  import stcsu_pkg::*;
#(
  parameter int ROWS        = ROWS_DEF,
  parameter int BUCKET_BITS = BUCKET_BITS_DEF
) (
  input  logic                     clk,
  input  sk_ctrl_t                 ctrl,
  input  logic [$clog2(ROWS * (1 << BUCKET_BITS))-1:0] addr,
  input  logic signed [DLT_W-1:0]  delta,
  output logic [ACC_W-1:0]         rd_data,
  output logic                     sat
);

  localparam int DEPTH = ROWS * (1 << BUCKET_BITS);

  logic [ACC_W-1:0] mem [DEPTH];
  logic [ACC_W-1:0] rd_data_r;
  logic [ACC_W:0]   sum;
  logic [ACC_W-1:0] sum_sat;

  // 49-bit sum cannot wrap; overflow shows as a mismatch of the top two bits
  assign sum = {rd_data_r[ACC_W-1], rd_data_r} +
               {{(ACC_W + 1 - DLT_W){delta[DLT_W-1]}}, delta};
  assign sat = sum[ACC_W] ^ sum[ACC_W-1];

  always_comb begin
    if (!sat) begin
      sum_sat = sum[ACC_W-1:0];
    end else if (sum[ACC_W]) begin
      sum_sat = {1'b1, {(ACC_W - 1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(ACC_W - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      mem[addr] <= '0;
    end else if (ctrl.acc) begin
      mem[addr] <= sum_sat;
    end
    if (ctrl.rd) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/signed_tensor_count_sketch_update.sv
// ----------------------------------------------------------------------------
// signed_tensor_count_sketch_update
// Tensor count sketch update engine with per-mode, per-row hash tables.
// ----------------------------------------------------------------------------
// Items enter on the in_ stream, one result per item leaves on the out_ stream.
// in_tuser carries the item kind: load hash entry, add entry, read bucket,
// clear sketch. active_modes is written through cfg_we/cfg_wdata; the user is
// to write it only while idle, the block itself does not enforce this.
// One item is processed at a time; in_tready is high only when the engine is
// idle. A load or read goes from S_EXEC to S_RESP; a clear sweeps the sketch
// memory in S_CLEAR first; an add runs, for each row, the mode lookups in
// S_HASH, then S_SKRD and S_SKWR. The add rate is set by the single hash
// table read port (one mode lookup per cycle) and the sketch memory
// read-modify-write. After reset the engine sweeps the sketch memory to
// zero, one bucket per cycle, before raising in_tready; cfg writes are taken
// during the sweep. Hash tables are not cleared. A stalled out_tready holds
// the result in the output register; the engine finishes the next item and
// then waits until the register is free.
// ----------------------------------------------------------------------------
module signed_tensor_count_sketch_update
  import stcsu_pkg::*;
#(
  parameter int ROWS        = ROWS_DEF,
  parameter int BUCKET_BITS = BUCKET_BITS_DEF,
  parameter int INDEX_DEPTH = INDEX_DEPTH_DEF,
  parameter int MAX_MODES   = MAX_MODES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // mode[1:0] row[3:2] index_a[13:4] index_b[23:14] index_c[33:24]
  // bucket[43:34] sign[44] value[76:45] zero[79:77]
  input  logic [79:0] in_tdata,
  // kind[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_value[47:0] saturated[48] status[49] zero[55:50]
  output logic [55:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata
);

  localparam int NBKT     = 1 << BUCKET_BITS;
  localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SK_DEPTH = ROWS * NBKT;
  localparam int SK_AW    = $clog2(SK_DEPTH);
  localparam int H_DEPTH  = MAX_MODES * ROWS * INDEX_DEPTH;
  localparam int HA_W     = $clog2(H_DEPTH);
  localparam int HW_W     = BUCKET_BITS + 1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLEAR = 7'b0000010,
    S_EXEC  = 7'b0000100,
    S_HASH  = 7'b0001000,
    S_SKRD  = 7'b0010000,
    S_SKWR  = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // accepted item
  kind_t                   kind_r;
  logic [MODE_W-1:0]       mode_r;
  logic [ROWF_W-1:0]       row_r;
  logic [IDX_W-1:0]        idx_a_r, idx_b_r, idx_c_r;
  logic [BKT_W-1:0]        bucket_r;
  logic                    sign_r;
  logic signed [VAL_W-1:0] value_r;

  logic [1:0]              active_modes_r, active_modes_nxt;
  logic [1:0]              m_r, m_nxt;
  logic [ROW_W-1:0]        rc_r, rc_nxt;
  logic [BUCKET_BITS-1:0]  sum_r, sum_nxt;
  logic                    neg_r, neg_nxt;
  logic [SK_AW-1:0]        sk_addr_r, sk_addr_nxt;
  logic signed [DLT_W-1:0] delta_r, delta_nxt;
  logic                    sat_r, sat_nxt;
  logic                    status_r, status_nxt;
  logic [SK_AW-1:0]        clr_cnt_r, clr_cnt_nxt;
  logic                    init_r, init_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [55:0]             out_data_r, out_data_nxt;

  logic                    in_xfer;
  logic [1:0]              n_modes;
  logic                    load_bad, add_bad, read_bad;
  logic [1:0]              h_mode;
  logic [ROWF_W-1:0]       h_row_item;
  logic [IDX_W-1:0]        h_idx;
  logic [HA_W-1:0]         h_addr;
  logic                    h_we, h_re;
  logic [HW_W-1:0]         hmem [H_DEPTH];
  logic [HW_W-1:0]         h_rdata_r;
  logic                    hv_r;
  logic [BUCKET_BITS-1:0]  bsum;
  logic                    nneg;
  logic signed [DLT_W-1:0] val_ext;
  sk_ctrl_t                sk_ctrl;
  logic [SK_AW-1:0]        sk_addr;
  logic [ACC_W-1:0]        sk_rd_data;
  logic                    sk_sat;
  logic [ACC_W-1:0]        rd_value;
  logic                    out_load;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  // item registers hold payload only
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_r   <= kind_t'(in_tuser);
      mode_r   <= in_tdata[1:0];
      row_r    <= in_tdata[3:2];
      idx_a_r  <= in_tdata[13:4];
      idx_b_r  <= in_tdata[23:14];
      idx_c_r  <= in_tdata[33:24];
      bucket_r <= in_tdata[43:34];
      sign_r   <= in_tdata[44];
      value_r  <= in_tdata[76:45];
    end
  end

  // mode count: zero acts as one, above the maximum acts as the maximum
  always_comb begin
    if (active_modes_r == 2'd0) begin
      n_modes = 2'd1;
    end else if (32'(active_modes_r) > MAX_MODES) begin
      n_modes = 2'(MAX_MODES);
    end else begin
      n_modes = active_modes_r;
    end
  end

  assign load_bad = (32'(mode_r) >= MAX_MODES) || (32'(row_r) >= ROWS) ||
                    (32'(idx_a_r) >= INDEX_DEPTH) || (32'(bucket_r) >= NBKT);
  assign add_bad  = (32'(idx_a_r) >= INDEX_DEPTH) ||
                    ((n_modes >= 2'd2) && (32'(idx_b_r) >= INDEX_DEPTH)) ||
                    ((n_modes == 2'd3) && (32'(idx_c_r) >= INDEX_DEPTH));
  assign read_bad = (32'(row_r) >= ROWS) || (32'(bucket_r) >= NBKT);

  // hash table port: add lookups during S_HASH, loads otherwise
  always_comb begin
    h_mode     = (state_r == S_HASH) ? m_r : mode_r;
    h_row_item = row_r;
    if (state_r == S_HASH) begin
      case (m_r)
        2'd0:    h_idx = idx_a_r;
        2'd1:    h_idx = idx_b_r;
        default: h_idx = idx_c_r;
      endcase
    end else begin
      // a load always indexes its table with index_a
      h_idx = idx_a_r;
    end
    if (state_r == S_HASH) begin
      h_addr = HA_W'((32'(m_r) * ROWS + 32'(rc_r)) * INDEX_DEPTH + 32'(h_idx));
    end else begin
      h_addr = HA_W'((32'(h_mode) * ROWS + 32'(h_row_item)) * INDEX_DEPTH + 32'(h_idx));
    end
  end

  assign h_we = (state_r == S_EXEC) && (kind_r == KIND_LOAD) && !load_bad;
  assign h_re = (state_r == S_HASH);

  always_ff @(posedge clk) begin
    if (h_we) begin
      hmem[h_addr] <= {sign_r, BUCKET_BITS'(bucket_r)};
    end
    if (h_re) begin
      h_rdata_r <= hmem[h_addr];
    end
  end

  // last lookup of a row lands in S_SKRD and is folded in there
  assign bsum    = sum_r + h_rdata_r[BUCKET_BITS-1:0];
  assign nneg    = neg_r ^ h_rdata_r[BUCKET_BITS];
  assign val_ext = DLT_W'(value_r);

  always_comb begin
    sk_ctrl = '0;
    case (state_r)
      S_CLEAR: begin
        sk_ctrl.clr = 1'b1;
        sk_addr     = clr_cnt_r;
      end
      S_SKRD: begin
        sk_ctrl.rd = 1'b1;
        sk_addr    = SK_AW'({rc_r, bsum});
      end
      S_SKWR: begin
        sk_ctrl.acc = 1'b1;
        sk_addr     = sk_addr_r;
      end
      S_EXEC: begin
        sk_ctrl.rd = (kind_r == KIND_READ) && !read_bad;
        sk_addr    = SK_AW'({ROW_W'(row_r), BUCKET_BITS'(bucket_r)});
      end
      default: begin
        sk_addr = sk_addr_r;
      end
    endcase
  end

  stcsu_sketch #(
    .ROWS        (ROWS),
    .BUCKET_BITS (BUCKET_BITS)
  ) u_sketch (
    .clk     (clk),
    .ctrl    (sk_ctrl),
    .addr    (sk_addr),
    .delta   (delta_r),
    .rd_data (sk_rd_data),
    .sat     (sk_sat)
  );

  assign rd_value = ((kind_r == KIND_READ) && !status_r) ? sk_rd_data : '0;
  assign out_load = (state_r == S_RESP) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt        = state_r;
    active_modes_nxt = cfg_we ? cfg_wdata : active_modes_r;
    m_nxt            = m_r;
    rc_nxt           = rc_r;
    sum_nxt          = sum_r;
    neg_nxt          = neg_r;
    sk_addr_nxt      = sk_addr_r;
    delta_nxt        = delta_r;
    sat_nxt          = sat_r;
    status_nxt       = status_r;
    clr_cnt_nxt      = clr_cnt_r;
    init_nxt         = init_r;
    out_valid_nxt    = (out_valid_r && out_tready) ? 1'b0 : out_valid_r;
    out_data_nxt     = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_EXEC;
        end
      end
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (32'(clr_cnt_r) == SK_DEPTH - 1) begin
          clr_cnt_nxt = '0;
          init_nxt    = 1'b0;
          state_nxt   = init_r ? S_IDLE : S_RESP;
        end
      end
      S_EXEC: begin
        sat_nxt    = 1'b0;
        status_nxt = 1'b0;
        unique case (kind_r)
          KIND_LOAD: begin
            status_nxt = load_bad;
            state_nxt  = S_RESP;
          end
          KIND_ADD: begin
            status_nxt = add_bad;
            m_nxt      = '0;
            rc_nxt     = '0;
            sum_nxt    = '0;
            neg_nxt    = 1'b0;
            state_nxt  = add_bad ? S_RESP : S_HASH;
          end
          KIND_READ: begin
            status_nxt = read_bad;
            state_nxt  = S_RESP;
          end
          KIND_CLEAR: begin
            clr_cnt_nxt = '0;
            state_nxt   = S_CLEAR;
          end
        endcase
      end
      S_HASH: begin
        if (hv_r) begin
          sum_nxt = bsum;
          neg_nxt = nneg;
        end
        m_nxt = m_r + 2'd1;
        if (m_r == n_modes - 2'd1) begin
          state_nxt = S_SKRD;
        end
      end
      S_SKRD: begin
        sk_addr_nxt = SK_AW'({rc_r, bsum});
        delta_nxt   = nneg ? -val_ext : val_ext;
        state_nxt   = S_SKWR;
      end
      S_SKWR: begin
        sat_nxt = sat_r | sk_sat;
        m_nxt   = '0;
        sum_nxt = '0;
        neg_nxt = 1'b0;
        if (32'(rc_r) == ROWS - 1) begin
          state_nxt = S_RESP;
        end else begin
          rc_nxt    = rc_r + 1'b1;
          state_nxt = S_HASH;
        end
      end
      S_RESP: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'd0, status_r, sat_r, rd_value};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      active_modes_r <= 2'd3;
      clr_cnt_r      <= '0;
      init_r         <= 1'b1;
      out_valid_r    <= 1'b0;
      hv_r           <= 1'b0;
      m_r            <= '0;
      rc_r           <= '0;
    end else begin
      state_r        <= state_nxt;
      active_modes_r <= active_modes_nxt;
      clr_cnt_r      <= clr_cnt_nxt;
      init_r         <= init_nxt;
      out_valid_r    <= out_valid_nxt;
      hv_r           <= (state_r == S_HASH);
      m_r            <= m_nxt;
      rc_r           <= rc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r      <= sum_nxt;
    neg_r      <= neg_nxt;
    sk_addr_r  <= sk_addr_nxt;
    delta_r    <= delta_nxt;
    sat_r      <= sat_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
